FILE: hw/rtl/keyboard_report_key_event_diff_core_defines.svh
// assertion macros for the keyboard report differ
// used by the top level only, no other dependencies
`ifndef KEYBOARD_REPORT_KEY_EVENT_DIFF_CORE_DEFINES_SVH
`define KEYBOARD_REPORT_KEY_EVENT_DIFF_CORE_DEFINES_SVH
`ifndef SYNTH
`define KB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define KB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset check failed");
`else
`define KB_ASSERT(lbl, prop)
`define KB_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: hw/rtl/kbdiff_pkg.sv
// shared types, constants and note rom for the keyboard report differ
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kbdiff_pkg;

  localparam int IN_SLOTS = 6;
  localparam int ROM_SIZE = 57;
  localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;
  localparam logic [7:0] FIRST_REAL_KEY = 8'd4;
  localparam logic [7:0] NO_NOTE = 8'hFF;
  localparam logic KIND_PRESS = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic [6:0] report_length;
    logic [7:0] slot_key_0;
    logic [7:0] slot_key_1;
    logic [7:0] slot_key_2;
    logic [7:0] slot_key_3;
    logic [7:0] slot_key_4;
    logic [7:0] slot_key_5;
  } kbdiff_in_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] event_key;
    logic       note_valid;
    logic [4:0] note_index;
    logic       last_event;
  } kbdiff_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN
  } kbdiff_state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
    logic commit;
  } kbdiff_cmd_t;

  typedef struct packed {
    logic len_ok;
    logic pending_any;
    logic out_free;
  } kbdiff_status_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] index;
  } note_t;

  localparam logic [7:0] NOTE_ROM [ROM_SIZE] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'd16, 8'd12, 8'hFF, 8'd4,  8'd13, 8'd15, 8'hFF,
    8'hFF, 8'd18, 8'd20, 8'd22, 8'd19, 8'd17, 8'hFF, 8'hFF,
    8'd0,  8'd5,  8'hFF, 8'd7,  8'd11, 8'd14, 8'd2,  8'hFF,
    8'd9,  8'hFF,
    8'hFF, 8'd1,  8'd3,  8'hFF, 8'd6,  8'd8,  8'd10, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'd21, 8'd23, 8'hFF
  };

  function automatic note_t note_lookup(logic [7:0] key);
    note_t      res;
    logic [7:0] n;
    n = NO_NOTE;
    if (key >= FIRST_REAL_KEY && key < 8'(ROM_SIZE)) begin
      n = NOTE_ROM[key[5:0]];
    end
    res.valid = (n != NO_NOTE);
    res.index = res.valid ? n[4:0] : 5'd0;
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kbdiff_if.sv
// valid/ready channel interfaces for report input and event output
// depends on kbdiff_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kbdiff_in_if;
  import kbdiff_pkg::*;
  logic       valid;
  logic       ready;
  kbdiff_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kbdiff_out_if;
  import kbdiff_pkg::*;
  logic        valid;
  logic        ready;
  kbdiff_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/keyboard_report_key_event_diff_core.sv
// top level of the keyboard report differ: controller plus datapath
// depends on kbdiff_pkg, kbdiff_if, kbdiff_ctrl, kbdiff_dp and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_report_key_event_diff_core_defines.svh"

// Compares each boot keyboard report with the keys held from the previous one and
// sends release and press events in slot order, one event per transfer, with the
// note index from the fixed key map and a flag on the final event of the report.
// Reports shorter than 8 bytes are taken and dropped. A full report is loaded, its
// release and press flags are computed, and its events, up to 2*KEY_SLOTS of them,
// go out through the single event output register, which a stalled output channel
// holds; no new report is taken until every event has entered that register. The next
// report is taken while the last event still waits in the output register.
module keyboard_report_key_event_diff_core #(
  parameter int KEY_SLOTS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  kbdiff_in_if.sink     in_ch,
  kbdiff_out_if.source  out_ch
);
  import kbdiff_pkg::*;

  kbdiff_cmd_t    cmd;
  kbdiff_status_t status;

  kbdiff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  kbdiff_dp #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

  `KB_ASSERT(a_short_dropped, (in_ch.valid && in_ch.ready && !status.len_ok) |=> in_ch.ready)
  `KB_ASSERT(a_full_busy, (in_ch.valid && in_ch.ready && status.len_ok) |=> !in_ch.ready)
  `KB_ASSERT(a_out_hold, (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
  `KB_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_ch.valid)

endmodule

`default_nettype wire

FILE: hw/rtl/kbdiff_dp.sv
// datapath: held and new key slots, pending event flags, event output register
// depends on kbdiff_pkg
`timescale 1ns / 1ps
`default_nettype none

module kbdiff_dp #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kbdiff_pkg::kbdiff_in_t   in_data,
  input  kbdiff_pkg::kbdiff_cmd_t  cmd,
  output kbdiff_pkg::kbdiff_status_t status,
  input  logic                     out_ready,
  output logic                     out_valid,
  output kbdiff_pkg::kbdiff_out_t  out_data
);
  import kbdiff_pkg::*;

  localparam int NCAND  = 2 * KEY_SLOTS;
  localparam int CAND_W = $clog2(NCAND);
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic [7:0]       held_r [KEY_SLOTS];
  logic [7:0]       now_r  [KEY_SLOTS];
  logic [7:0]       now_in [KEY_SLOTS];
  logic [7:0]       in_keys [IN_SLOTS];
  logic [NCAND-1:0] pend_r;
  logic [NCAND-1:0] pend_calc;
  logic [NCAND-1:0] pend_clr;
  logic [CAND_W-1:0] sel;
  logic [SLOT_W-1:0] sel_slot;
  logic [7:0]       sel_key;
  note_t            sel_note;
  logic             ovalid_r;
  kbdiff_out_t      obuf_r;
  kbdiff_out_t      obuf_nxt;

  assign in_keys[0] = in_data.slot_key_0;
  assign in_keys[1] = in_data.slot_key_1;
  assign in_keys[2] = in_data.slot_key_2;
  assign in_keys[3] = in_data.slot_key_3;
  assign in_keys[4] = in_data.slot_key_4;
  assign in_keys[5] = in_data.slot_key_5;

  // slots beyond the report read as empty
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_now
    if (g < IN_SLOTS) begin : g_real
      assign now_in[g] = in_keys[g];
    end else begin : g_pad
      assign now_in[g] = 8'd0;
    end
  end

  // release flag at even position, press flag at odd position of each slot
  always_comb begin
    logic rel;
    logic prs;
    pend_calc = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      rel = (held_r[i] >= FIRST_REAL_KEY);
      prs = (now_r[i] >= FIRST_REAL_KEY);
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (now_r[j] == held_r[i]) begin
          rel = 1'b0;
        end
        if (held_r[j] == now_r[i]) begin
          prs = 1'b0;
        end
      end
      pend_calc[2*i]   = rel;
      pend_calc[2*i+1] = prs;
    end
  end

  // lowest pending event goes first
  always_comb begin
    sel = '0;
    for (int p = NCAND - 1; p >= 0; p--) begin
      if (pend_r[p]) begin
        sel = CAND_W'(p);
      end
    end
  end

  assign pend_clr = pend_r & ~(NCAND'(1) << sel);
  assign sel_slot = SLOT_W'(sel >> 1);
  assign sel_key  = sel[0] ? now_r[sel_slot] : held_r[sel_slot];
  assign sel_note = note_lookup(sel_key);

  always_comb begin
    obuf_nxt.event_kind = sel[0] ? KIND_PRESS : KIND_RELEASE;
    obuf_nxt.event_key  = sel_key;
    obuf_nxt.note_valid = sel_note.valid;
    obuf_nxt.note_index = sel_note.index;
    obuf_nxt.last_event = (pend_clr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_r[i] <= 8'd0;
      end
      pend_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        now_r <= now_in;
      end
      if (cmd.calc) begin
        pend_r <= pend_calc;
      end else if (cmd.emit) begin
        pend_r <= pend_clr;
      end
      if (cmd.commit) begin
        held_r <= now_r;
      end
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      obuf_r <= obuf_nxt;
    end
  end

  assign status.len_ok      = (in_data.report_length >= MIN_REPORT_BYTES);
  assign status.pending_any = |pend_r;
  assign status.out_free    = !ovalid_r || out_ready;
  assign out_valid          = ovalid_r;
  assign out_data           = obuf_r;

endmodule

`default_nettype wire

FILE: hw/rtl/kbdiff_ctrl.sv
// controller: sequences report load, flag compare, event output and slot update
// depends on kbdiff_pkg
`timescale 1ns / 1ps
`default_nettype none

module kbdiff_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kbdiff_pkg::kbdiff_status_t status,
  output kbdiff_pkg::kbdiff_cmd_t    cmd
);
  import kbdiff_pkg::*;

  kbdiff_state_t state_r;
  kbdiff_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // short reports are taken and dropped
        if (in_valid && status.len_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.pending_any) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sim/keyboard_report_key_event_diff_core_tb.sv
// testbench for keyboard_report_key_event_diff_core: random and directed reports in,
// press and release events checked against an in-bench key differ with its own note map
// depends on kbdiff_pkg, kbdiff_if and the core rtl
`timescale 1ns / 1ps

module keyboard_report_key_event_diff_core_tb;
  import kbdiff_pkg::*;

  localparam int RANDOM_REPORTS = 350;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_EVENTS = 2 * IN_SLOTS;

  // note per usage code, index 0 leftmost
  localparam logic [0:56][7:0] KEY_NOTE_MAP = {
    NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE,
    NO_NOTE, 8'd16, 8'd12, NO_NOTE, 8'd4, 8'd13, 8'd15, NO_NOTE,
    NO_NOTE, 8'd18, 8'd20, 8'd22, 8'd19, 8'd17, NO_NOTE, NO_NOTE,
    8'd0, 8'd5, NO_NOTE, 8'd7, 8'd11, 8'd14, 8'd2, NO_NOTE,
    8'd9, NO_NOTE,
    NO_NOTE, 8'd1, 8'd3, NO_NOTE, 8'd6, 8'd8, 8'd10, NO_NOTE, NO_NOTE, NO_NOTE,
    NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE,
    NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE, NO_NOTE,
    8'd21, 8'd23, NO_NOTE
  };

  logic clk;
  logic rst_n;

  kbdiff_in_if  in_ch ();
  kbdiff_out_if out_ch ();

  keyboard_report_key_event_diff_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kbdiff_in_t                  report_q [$];
  kbdiff_out_t                 pending_events [$];
  logic [IN_SLOTS-1:0][7:0]    model_held = '0;
  int                          total_reports = 0;
  int                          reports_taken = 0;
  int                          mismatch_count = 0;
  int                          stall_cycles = 0;
  logic                        in_taken = 1'b0;
  logic                        out_taken = 1'b0;
  int                          send_gap = 0;
  int                          recv_gap = 0;
  int                          hold_left = 0;
  int                          holds_done = 0;
  logic                        send_bursty = 1'b1;
  logic                        recv_bursty = 1'b1;

  always #5 clk = ~clk;

  function automatic logic key_in(input logic [IN_SLOTS-1:0][7:0] set,
                                  input logic [7:0] key);
    for (int i = 0; i < IN_SLOTS; i++) begin
      if (set[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic kbdiff_out_t make_event(input logic kind, input logic [7:0] key);
    kbdiff_out_t ev;
    logic [7:0]  note;
    note = NO_NOTE;
    if (key >= FIRST_REAL_KEY && int'(key) < ROM_SIZE) note = KEY_NOTE_MAP[key];
    ev.event_kind = kind;
    ev.event_key  = key;
    ev.note_valid = (note != NO_NOTE);
    ev.note_index = (note != NO_NOTE) ? note[4:0] : 5'd0;
    ev.last_event = 1'b0;
    return ev;
  endfunction

  // compute the events of one accepted report and update the held keys
  task automatic diff_report(input kbdiff_in_t r);
    logic [IN_SLOTS-1:0][7:0] cur;
    kbdiff_out_t              evs [MAX_EVENTS];
    int                       n;
    n = 0;
    cur = {r.slot_key_5, r.slot_key_4, r.slot_key_3,
           r.slot_key_2, r.slot_key_1, r.slot_key_0};
    if (r.report_length < MIN_REPORT_BYTES) return;
    for (int i = 0; i < IN_SLOTS; i++) begin
      if (model_held[i] >= FIRST_REAL_KEY && !key_in(cur, model_held[i])) begin
        evs[n] = make_event(KIND_RELEASE, model_held[i]);
        n++;
      end
      if (cur[i] >= FIRST_REAL_KEY && !key_in(model_held, cur[i])) begin
        evs[n] = make_event(KIND_PRESS, cur[i]);
        n++;
      end
    end
    if (n > 0) evs[n-1].last_event = 1'b1;
    for (int i = 0; i < n; i++) pending_events.push_back(evs[i]);
    model_held = cur;
  endtask

  task automatic compare_event_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_report(input logic [6:0] len, input logic [7:0] k0, input logic [7:0] k1,
                            input logic [7:0] k2, input logic [7:0] k3,
                            input logic [7:0] k4, input logic [7:0] k5);
    kbdiff_in_t r;
    r.report_length = len;
    r.slot_key_0 = k0;
    r.slot_key_1 = k1;
    r.slot_key_2 = k2;
    r.slot_key_3 = k3;
    r.slot_key_4 = k4;
    r.slot_key_5 = k5;
    report_q.push_back(r);
  endtask

  // report driver
  always @(negedge clk) begin : drive_reports
    logic       nxt_valid;
    kbdiff_in_t nxt_data;
    nxt_valid = in_ch.valid && !in_taken;
    nxt_data  = in_ch.data;
    if (rst_n && !nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (report_q.size() != 0) begin
        nxt_data  = report_q.pop_front();
        nxt_valid = 1'b1;
        if ($urandom_range(0, 29) == 0) send_bursty = !send_bursty;
        send_gap = send_bursty ? $urandom_range(0, 14) : 0;
      end
    end
    in_ch.valid <= nxt_valid;
    in_ch.data  <= nxt_data;
  end

  // event receiver, with two long hold-offs to back up the core
  always @(negedge clk) begin : drive_ready
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (hold_left == 0 && holds_done < 2 && reports_taken >= (holds_done + 1) * 120) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) recv_bursty = !recv_bursty;
        recv_gap = recv_bursty ? $urandom_range(0, 14) : 0;
      end
      if (hold_left > 0) hold_left--;
      else if (recv_gap > 0) recv_gap--;
      else nxt_ready = 1'b1;
    end
    out_ch.ready <= nxt_ready;
  end

  // transfer monitor, event checker and watchdog
  always @(posedge clk) begin : watch_channels
    kbdiff_out_t want;
    in_taken  = rst_n && in_ch.valid && in_ch.ready;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (out_taken) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %p", $time, out_ch.data);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        compare_event_field("event_kind", want.event_kind, out_ch.data.event_kind);
        compare_event_field("event_key", want.event_key, out_ch.data.event_key);
        compare_event_field("note_valid", want.note_valid, out_ch.data.note_valid);
        compare_event_field("note_index", want.note_index, out_ch.data.note_index);
        compare_event_field("last_event", want.last_event, out_ch.data.last_event);
      end
    end
    if (in_taken) begin
      diff_report(in_ch.data);
      reports_taken++;
    end
    if (!rst_n || in_taken || out_taken) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : run_test
    logic [IN_SLOTS-1:0][7:0] keys;
    logic [6:0]               len;
    logic [7:0]               tmp;
    int                       pick;
    int                       a;
    int                       b;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    clk = 1'b0;

    add_report(7'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_report(7'd8, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
    add_report(7'd8, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4);
    // short reports are dropped, longer reports are kept
    add_report(7'd0, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15);
    add_report(7'd7, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25);
    add_report(7'd64, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_report(7'd127, 8'd54, 8'd55, 8'd56, 8'd57, 8'd255, 8'd128);
    // rollover and reserved codes
    add_report(7'd8, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    add_report(7'd8, 8'd2, 8'd3, 8'd0, 8'd1, 8'd2, 8'd3);
    // repeated keys
    add_report(7'd8, 8'd20, 8'd20, 8'd20, 8'd0, 8'd0, 8'd0);
    add_report(7'd8, 8'd0, 8'd20, 8'd0, 8'd0, 8'd0, 8'd20);
    add_report(7'd8, 8'd31, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_report(7'd8, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd22);
    add_report(7'd8, 8'd33, 8'd34, 8'd35, 8'd36, 8'd28, 8'd26);
    add_report(7'd9, 8'd12, 8'd13, 8'd14, 8'd24, 8'd25, 8'd23);
    add_report(7'd8, 8'd255, 8'd254, 8'd128, 8'd127, 8'd64, 8'd57);
    add_report(7'd8, 8'd170, 8'd85, 8'd15, 8'd240, 8'd204, 8'd51);
    add_report(7'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_report(7'd6, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10);
    add_report(7'd8, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
    // full turnover: release and press in every slot
    add_report(7'd8, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6);

    // random reports evolve from the previous one so keys stay held across reports
    keys = '0;
    for (int n = 0; n < RANDOM_REPORTS; n++) begin
      for (int s = 0; s < IN_SLOTS; s++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) keys[s] = 8'd0;
        else if (pick < 40) keys[s] = 8'($urandom_range(4, 56));
        else if (pick < 48) keys[s] = 8'($urandom_range(0, 255));
        else if (pick < 52) keys[s] = 8'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 4) == 0) begin
        a = $urandom_range(0, IN_SLOTS - 1);
        b = $urandom_range(0, IN_SLOTS - 1);
        tmp = keys[a];
        keys[a] = keys[b];
        keys[b] = tmp;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 7'($urandom_range(0, 7));
      else if (pick < 20) len = 7'($urandom_range(9, 127));
      else len = MIN_REPORT_BYTES;
      add_report(len, keys[0], keys[1], keys[2], keys[3], keys[4], keys[5]);
    end
    total_reports = report_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (reports_taken < total_reports) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/kbdiff_pkg.sv
hw/rtl/kbdiff_if.sv
hw/rtl/kbdiff_dp.sv
hw/rtl/kbdiff_ctrl.sv
hw/rtl/keyboard_report_key_event_diff_core.sv
sim/keyboard_report_key_event_diff_core_tb.sv
